[hw/rtl/bbmt_pkg.sv]
// bbmt_pkg: types, constants, beat layouts and the microcode table of the blob tracker
// used by blob_blink_motion_tracker, bbmt_checker and the testbench; no dependencies of its own

package bbmt_pkg;

    // field layout of the input beat (tdata), lowest bit first
    localparam int IN_DATA_W     = 88;
    localparam int IN_PRESENT    = 0;
    localparam int IN_X_LSB      = 1;
    localparam int IN_Y_LSB      = 13;
    localparam int IN_AREA_LSB   = 25;
    localparam int IN_TIME_LSB   = 49;

    // field layout of the output beat (tdata), lowest bit first
    localparam int OUT_DATA_W    = 104;
    localparam int OUT_ON        = 0;
    localparam int OUT_COUNT_LSB = 1;
    localparam int OUT_VX_LSB    = 17;
    localparam int OUT_VY_LSB    = 30;
    localparam int OUT_GROW_LSB  = 43;
    localparam int OUT_RATE_LSB  = 75;
    localparam int OUT_PAD_W     = 3;

    // arithmetic constants
    localparam logic [25:0] RATE_NUM     = 26'd65536000;
    localparam logic [31:0] GROWTH_MAX   = 32'h7FFF_FFFF;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [7:0]  THR_RESET    = 8'd5;

    // shared divider: 40-bit dividend register, iteration counts per use
    localparam int          DIV_N_W      = 40;
    localparam int          DIV_CNT_W    = 6;
    localparam logic [5:0]  RATE_ITERS   = 6'd26;
    localparam logic [5:0]  GROWTH_ITERS = 6'd40;

    // step numbers of the program
    typedef logic [3:0] step_t;
    localparam step_t STEP_WAIT         = 4'd0;
    localparam step_t STEP_EVAL         = 4'd1;
    localparam step_t STEP_BLINK_CHK    = 4'd2;
    localparam step_t STEP_RATE_LOAD    = 4'd3;
    localparam step_t STEP_RATE_DIV     = 4'd4;
    localparam step_t STEP_RATE_STORE   = 4'd5;
    localparam step_t STEP_GROWTH_LOAD  = 4'd6;
    localparam step_t STEP_GROWTH_DIV   = 4'd7;
    localparam step_t STEP_GROWTH_STORE = 4'd8;
    localparam step_t STEP_UPD_PREV     = 4'd9;
    localparam step_t STEP_EMIT         = 4'd10;
    localparam step_t STEP_RETURN       = 4'd11;

    // datapath action of one step
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_EVAL,
        ACT_RATE_LOAD,
        ACT_DIV_ITER,
        ACT_RATE_STORE,
        ACT_GROWTH_LOAD,
        ACT_GROWTH_STORE,
        ACT_UPD_PREV,
        ACT_EMIT
    } act_t;

    // jump condition of one step; when false the program falls through
    typedef enum logic [3:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NO_BEAT,
        JMP_SKIP_STABLE,
        JMP_NO_NEW_BLINK,
        JMP_PERIOD_ZERO,
        JMP_DIV_MORE,
        JMP_PREV_AREA_ZERO,
        JMP_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    // microcode table
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            STEP_WAIT:         w = '{ACT_LOAD,         JMP_NO_BEAT,        STEP_WAIT};
            STEP_EVAL:         w = '{ACT_EVAL,         JMP_SKIP_STABLE,    STEP_UPD_PREV};
            STEP_BLINK_CHK:    w = '{ACT_NOP,          JMP_NO_NEW_BLINK,   STEP_GROWTH_LOAD};
            STEP_RATE_LOAD:    w = '{ACT_RATE_LOAD,    JMP_PERIOD_ZERO,    STEP_GROWTH_LOAD};
            STEP_RATE_DIV:     w = '{ACT_DIV_ITER,     JMP_DIV_MORE,       STEP_RATE_DIV};
            STEP_RATE_STORE:   w = '{ACT_RATE_STORE,   JMP_NEVER,          STEP_WAIT};
            STEP_GROWTH_LOAD:  w = '{ACT_GROWTH_LOAD,  JMP_PREV_AREA_ZERO, STEP_UPD_PREV};
            STEP_GROWTH_DIV:   w = '{ACT_DIV_ITER,     JMP_DIV_MORE,       STEP_GROWTH_DIV};
            STEP_GROWTH_STORE: w = '{ACT_GROWTH_STORE, JMP_NEVER,          STEP_WAIT};
            STEP_UPD_PREV:     w = '{ACT_UPD_PREV,     JMP_NEVER,          STEP_WAIT};
            STEP_EMIT:         w = '{ACT_EMIT,         JMP_OUT_BUSY,       STEP_EMIT};
            STEP_RETURN:       w = '{ACT_NOP,          JMP_ALWAYS,         STEP_WAIT};
            default:           w = '{ACT_NOP,          JMP_ALWAYS,         STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/blob_blink_motion_tracker.sv]
// blob_blink_motion_tracker: microcoded blink debouncer, rate and motion tracker
// depends on bbmt_pkg for the microcode table, beat layouts and constants
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------------------
//  s_*       | in        | tuser: cmd; tdata: present, pos_x, pos_y, area, time_ms
//  m_*       | out       | tuser: growth_invalid; tdata: blink_on, blink_count,
//            |           |   velocity_x, velocity_y, area_growth, blink_rate
//  cfg_*     | in        | cfg_wr_data: stable_threshold, written when cfg_wr_en
//
// an item's path through the steps sets its time: shortest for a clear command or an
// unstable frame, longest for a new blink plus growth, which runs the shared radix-2
// divider twice: 26 steps for the rate, 40 for the growth
// s_tready is high only in the wait step; the next item may enter while a result
// still sits in the output register, the emit step stalls only if that is still full
// reset clears all tracker state, sets the threshold to 5 and empties the output

module blob_blink_motion_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // input beat
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bbmt_pkg::IN_DATA_W-1:0]  s_tdata,   // present, pos_x, pos_y, area, time_ms
    input  logic                            s_tuser,   // cmd
    // result beat
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bbmt_pkg::OUT_DATA_W-1:0] m_tdata,   // blink_on, blink_count, velocity_x,
                                                       // velocity_y, area_growth, blink_rate
    output logic                            m_tuser,   // growth_invalid
    // threshold register
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data
);

    // sequencer
    bbmt_pkg::step_t  step_reg, step_next;
    bbmt_pkg::uword_t uw;
    logic             jump;

    // captured input item
    logic        cmd_reg;
    logic        present_reg;
    logic [11:0] x_reg, y_reg;
    logic [23:0] area_reg;
    logic [31:0] time_reg;

    // tracker state
    logic [7:0]         thr_reg;
    logic [7:0]         energy_reg;
    logic               active_reg;
    logic [15:0]        count_reg;
    logic [31:0]        last_reg;
    logic               prev_present_reg;
    logic [11:0]        prev_x_reg, prev_y_reg;
    logic [23:0]        prev_area_reg;
    logic signed [12:0] vel_x_reg, vel_y_reg;
    logic [31:0]        growth_reg;
    logic               growth_flag_reg;
    logic [25:0]        rate_reg;
    logic               new_blink_reg;

    // divider
    logic [31:0]                      div_rem_reg;
    logic [bbmt_pkg::DIV_N_W-1:0]     div_quo_reg;
    logic [31:0]                      div_den_reg;
    logic [bbmt_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic                             neg_reg;
    logic [32:0]                      div_shift, div_sub;
    logic                             div_ge;

    // output register
    logic                            out_valid_reg;
    logic [bbmt_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_user_reg;

    // combinational helpers
    logic        in_fire;
    logic        out_busy;
    logic [8:0]  energy_inc;
    logic        stable_hit;
    logic [31:0] period;
    logic [23:0] area_mag;
    logic        area_neg;
    logic signed [12:0] dx, dy;
    logic [bbmt_pkg::OUT_DATA_W-1:0] out_data_next;

    assign s_tready = (step_reg == bbmt_pkg::STEP_WAIT);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign out_busy = out_valid_reg && !m_tready;

    // frame decisions
    assign energy_inc = {1'b0, energy_reg} + 9'd1;
    assign stable_hit = present_reg && (energy_inc >= {1'b0, thr_reg});
    assign period     = time_reg - last_reg;
    assign area_neg   = (area_reg < prev_area_reg);
    assign area_mag   = area_neg ? (prev_area_reg - area_reg) : (area_reg - prev_area_reg);
    assign dx         = $signed({1'b0, x_reg}) - $signed({1'b0, prev_x_reg});
    assign dy         = $signed({1'b0, y_reg}) - $signed({1'b0, prev_y_reg});

    // one restoring divider step
    assign div_shift = {div_rem_reg, div_quo_reg[bbmt_pkg::DIV_N_W-1]};
    assign div_sub   = div_shift - {1'b0, div_den_reg};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});

    // result beat
    assign out_data_next = {{bbmt_pkg::OUT_PAD_W{1'b0}}, rate_reg, growth_reg,
                            vel_y_reg, vel_x_reg, count_reg, active_reg};

    // microcode fetch and jump decision
    always_comb
    begin
        uw = bbmt_pkg::ucode(step_reg);
        case (uw.cond)
            bbmt_pkg::JMP_NEVER:          jump = 1'b0;
            bbmt_pkg::JMP_ALWAYS:         jump = 1'b1;
            bbmt_pkg::JMP_NO_BEAT:        jump = !in_fire;
            bbmt_pkg::JMP_SKIP_STABLE:    jump = cmd_reg || !stable_hit;
            bbmt_pkg::JMP_NO_NEW_BLINK:   jump = !new_blink_reg;
            bbmt_pkg::JMP_PERIOD_ZERO:    jump = (period == 32'd0);
            bbmt_pkg::JMP_DIV_MORE:       jump = (div_cnt_reg != 6'd1);
            bbmt_pkg::JMP_PREV_AREA_ZERO: jump = (prev_area_reg == 24'd0);
            bbmt_pkg::JMP_OUT_BUSY:       jump = out_busy;
            default:                      jump = 1'b0;
        endcase
        step_next = jump ? uw.target : step_reg + 4'd1;
    end

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= bbmt_pkg::STEP_WAIT;
            thr_reg          <= bbmt_pkg::THR_RESET;
            energy_reg       <= '0;
            active_reg       <= 1'b0;
            count_reg        <= '0;
            last_reg         <= '0;
            prev_present_reg <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_area_reg    <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            growth_reg       <= '0;
            growth_flag_reg  <= 1'b0;
            rate_reg         <= '0;
            new_blink_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            // threshold register
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end

            // output handshake: a new beat in the emit step, else drop once taken
            if (uw.act == bbmt_pkg::ACT_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (uw.act)
                bbmt_pkg::ACT_EVAL:
                begin
                    // off to on on a stable present frame starts a blink
                    new_blink_reg <= !cmd_reg && stable_hit && !active_reg;
                    if (cmd_reg)
                    begin
                        // clear command keeps the previous frame
                        vel_x_reg       <= '0;
                        vel_y_reg       <= '0;
                        growth_reg      <= '0;
                        growth_flag_reg <= 1'b0;
                        rate_reg        <= '0;
                        count_reg       <= '0;
                        active_reg      <= 1'b0;
                        energy_reg      <= '0;
                        last_reg        <= '0;
                    end
                    else if (present_reg)
                    begin
                        if (stable_hit)
                        begin
                            energy_reg <= thr_reg;
                            if (!active_reg)
                            begin
                                active_reg <= 1'b1;
                                if (count_reg != bbmt_pkg::COUNT_MAX)
                                begin
                                    count_reg <= count_reg + 16'd1;
                                end
                            end
                            if (prev_present_reg)
                            begin
                                vel_x_reg <= dx;
                                vel_y_reg <= dy;
                            end
                        end
                        else
                        begin
                            energy_reg <= energy_inc[7:0];
                        end
                    end
                    else if (energy_reg <= 8'd1)
                    begin
                        energy_reg <= '0;
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        energy_reg <= energy_reg - 8'd1;
                    end
                end
                bbmt_pkg::ACT_RATE_LOAD:
                begin
                    last_reg <= time_reg;
                    // zero period saturates
                    if (period == 32'd0)
                    begin
                        rate_reg <= bbmt_pkg::RATE_NUM;
                    end
                end
                bbmt_pkg::ACT_RATE_STORE:
                begin
                    rate_reg <= div_quo_reg[25:0];
                end
                bbmt_pkg::ACT_GROWTH_LOAD:
                begin
                    if (prev_area_reg == 24'd0)
                    begin
                        growth_reg      <= bbmt_pkg::GROWTH_MAX;
                        growth_flag_reg <= 1'b1;
                    end
                    else
                    begin
                        growth_flag_reg <= 1'b0;
                    end
                end
                bbmt_pkg::ACT_GROWTH_STORE:
                begin
                    if (neg_reg)
                    begin
                        growth_reg <= 32'd0 - div_quo_reg[31:0];
                    end
                    else if (|div_quo_reg[bbmt_pkg::DIV_N_W-1:31])
                    begin
                        growth_reg <= bbmt_pkg::GROWTH_MAX;
                    end
                    else
                    begin
                        growth_reg <= div_quo_reg[31:0];
                    end
                end
                bbmt_pkg::ACT_UPD_PREV:
                begin
                    if (!cmd_reg)
                    begin
                        prev_present_reg <= present_reg;
                        prev_x_reg       <= x_reg;
                        prev_y_reg       <= y_reg;
                        prev_area_reg    <= area_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload: captured item, divider and output data
    always_ff @(posedge clk)
    begin
        case (uw.act)
            bbmt_pkg::ACT_LOAD:
            begin
                if (in_fire)
                begin
                    cmd_reg     <= s_tuser;
                    present_reg <= s_tdata[bbmt_pkg::IN_PRESENT];
                    x_reg       <= s_tdata[bbmt_pkg::IN_X_LSB +: 12];
                    y_reg       <= s_tdata[bbmt_pkg::IN_Y_LSB +: 12];
                    area_reg    <= s_tdata[bbmt_pkg::IN_AREA_LSB +: 24];
                    time_reg    <= s_tdata[bbmt_pkg::IN_TIME_LSB +: 32];
                end
            end
            bbmt_pkg::ACT_RATE_LOAD:
            begin
                // dividend aligned to the top so 26 steps suffice
                div_rem_reg <= '0;
                div_quo_reg <= {bbmt_pkg::RATE_NUM, 14'd0};
                div_den_reg <= period;
                div_cnt_reg <= bbmt_pkg::RATE_ITERS;
            end
            bbmt_pkg::ACT_GROWTH_LOAD:
            begin
                div_rem_reg <= '0;
                div_quo_reg <= {area_mag, 16'd0};
                div_den_reg <= {8'd0, prev_area_reg};
                div_cnt_reg <= bbmt_pkg::GROWTH_ITERS;
                neg_reg     <= area_neg;
            end
            bbmt_pkg::ACT_DIV_ITER:
            begin
                div_rem_reg <= div_ge ? div_sub[31:0] : div_shift[31:0];
                div_quo_reg <= {div_quo_reg[bbmt_pkg::DIV_N_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            bbmt_pkg::ACT_EMIT:
            begin
                if (!out_busy)
                begin
                    out_data_reg <= out_data_next;
                    out_user_reg <= growth_flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/bbmt_checker.sv]
// bbmt_checker: port-level assertions for blob_blink_motion_tracker, bound to the top
// depends on bbmt_pkg for the result beat layout and saturation constants

module bbmt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bbmt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // one item at a time: no second beat straight after an accepted one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // invalid growth always carries the saturated value
    a_growth_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            m_tdata[bbmt_pkg::OUT_GROW_LSB +: 32] == bbmt_pkg::GROWTH_MAX)
        else $error("growth_invalid without saturated growth");

    // blink rate never exceeds one blink per millisecond
    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[bbmt_pkg::OUT_RATE_LSB +: 26] <= bbmt_pkg::RATE_NUM)
        else $error("blink_rate above saturation value");

endmodule

bind blob_blink_motion_tracker bbmt_checker u_bbmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

// testbench for blob_blink_motion_tracker: directed and random frame beats checked
// against an in-bench model of the presence counter, blink rate, velocity and growth
// depends on bbmt_pkg for the beat widths and field positions

module testbench;

    typedef enum bit {CMD_FRAME = 1'b0, CMD_CLEAR = 1'b1} cmd_t;

    // one observation beat
    typedef struct {
        cmd_t      cmd;
        bit        present;
        bit [11:0] pos_x;
        bit [11:0] pos_y;
        bit [23:0] area;
        bit [31:0] time_ms;
    } frame_t;

    // one result beat
    typedef struct {
        logic               blink_on;
        logic [15:0]        blink_count;
        logic signed [12:0] vel_x;
        logic signed [12:0] vel_y;
        logic signed [31:0] growth;
        logic               growth_invalid;
        logic [25:0]        rate;
    } report_t;

    localparam bit [31:0] RATE_FULL   = 32'd65536000;
    localparam bit [31:0] GROWTH_TOP  = 32'h7FFF_FFFF;
    localparam bit [15:0] BLINKS_TOP  = 16'hFFFF;

    // tracker model plus queue of reports still owed by the block
    class frame_scoreboard;
        bit [7:0]         threshold;
        bit [7:0]         energy;
        bit               active;
        bit [15:0]        blinks;
        bit [31:0]        last_blink_at;
        bit               prev_present;
        bit [11:0]        prev_x;
        bit [11:0]        prev_y;
        bit [23:0]        prev_area;
        bit signed [12:0] vel_x;
        bit signed [12:0] vel_y;
        bit [31:0]        growth;
        bit               growth_bad;
        bit [25:0]        rate;
        report_t          due_reports[$];
        int               errors;

        function new();
            threshold     = 8'd5;
            energy        = '0;
            active        = 1'b0;
            blinks        = '0;
            last_blink_at = '0;
            prev_present  = 1'b0;
            prev_x        = '0;
            prev_y        = '0;
            prev_area     = '0;
            vel_x         = '0;
            vel_y         = '0;
            growth        = '0;
            growth_bad    = 1'b0;
            rate          = '0;
            errors        = 0;
        endfunction

        function void set_threshold(bit [7:0] value);
            threshold = value;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // relative area change in q16.16, saturating upwards
        function void update_growth(bit [23:0] cur);
            bit [63:0] q;
            if (prev_area == '0)
            begin
                growth     = GROWTH_TOP;
                growth_bad = 1'b1;
                return;
            end
            growth_bad = 1'b0;
            if (cur >= prev_area)
            begin
                q = {24'd0, cur - prev_area, 16'd0} / prev_area;
                growth = (q > GROWTH_TOP) ? GROWTH_TOP : q[31:0];
            end
            else
            begin
                q = {24'd0, prev_area - cur, 16'd0} / prev_area;
                growth = 32'd0 - q[31:0];
            end
        endfunction

        // advance the model by one accepted beat and queue the report it owes
        function void note_frame(frame_t f);
            bit [8:0]  next_energy;
            bit [31:0] period;
            bit [31:0] rate_q;
            report_t   r;
            if (f.cmd == CMD_CLEAR)
            begin
                vel_x         = '0;
                vel_y         = '0;
                growth        = '0;
                growth_bad    = 1'b0;
                rate          = '0;
                blinks        = '0;
                active        = 1'b0;
                energy        = '0;
                last_blink_at = '0;
            end
            else
            begin
                if (f.present)
                begin
                    next_energy = {1'b0, energy} + 9'd1;
                    if (next_energy >= {1'b0, threshold})
                    begin
                        energy = threshold;
                        // off to on: a new blink
                        if (!active)
                        begin
                            active = 1'b1;
                            if (blinks != BLINKS_TOP)
                                blinks++;
                            period        = f.time_ms - last_blink_at;
                            rate_q        = (period == '0) ? RATE_FULL : RATE_FULL / period;
                            rate          = rate_q[25:0];
                            last_blink_at = f.time_ms;
                        end
                        if (prev_present)
                        begin
                            vel_x = $signed({1'b0, f.pos_x}) - $signed({1'b0, prev_x});
                            vel_y = $signed({1'b0, f.pos_y}) - $signed({1'b0, prev_y});
                        end
                        update_growth(f.area);
                    end
                    else
                        energy = next_energy[7:0];
                end
                else
                begin
                    if (energy <= 8'd1)
                    begin
                        energy = '0;
                        active = 1'b0;
                    end
                    else
                        energy--;
                end
                prev_present = f.present;
                prev_x       = f.pos_x;
                prev_y       = f.pos_y;
                prev_area    = f.area;
            end
            r.blink_on       = active;
            r.blink_count    = blinks;
            r.vel_x          = vel_x;
            r.vel_y          = vel_y;
            r.growth         = growth;
            r.growth_invalid = growth_bad;
            r.rate           = rate;
            due_reports = {due_reports, r};
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // compare one accepted result beat with the oldest owed report
        task check_report(report_t got);
            report_t want;
            if (due_reports.size() == 0)
            begin
                report_mismatch("result beat with no frame waiting for it");
                return;
            end
            want = due_reports.pop_front();
            if (got.blink_on !== want.blink_on)
                report_mismatch($sformatf("blink_on got %0b want %0b",
                                          got.blink_on, want.blink_on));
            if (got.blink_count !== want.blink_count)
                report_mismatch($sformatf("blink_count got %0d want %0d",
                                          got.blink_count, want.blink_count));
            if (got.vel_x !== want.vel_x)
                report_mismatch($sformatf("velocity_x got %0d want %0d",
                                          got.vel_x, want.vel_x));
            if (got.vel_y !== want.vel_y)
                report_mismatch($sformatf("velocity_y got %0d want %0d",
                                          got.vel_y, want.vel_y));
            if (got.growth !== want.growth)
                report_mismatch($sformatf("area_growth got %0d want %0d",
                                          got.growth, want.growth));
            if (got.growth_invalid !== want.growth_invalid)
                report_mismatch($sformatf("growth_invalid got %0b want %0b",
                                          got.growth_invalid, want.growth_invalid));
            if (got.rate !== want.rate)
                report_mismatch($sformatf("blink_rate got %0d want %0d",
                                          got.rate, want.rate));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bbmt_pkg::IN_DATA_W-1:0]  s_tdata;   // present, pos_x, pos_y, area, time_ms
    logic                            s_tuser;   // cmd
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bbmt_pkg::OUT_DATA_W-1:0] m_tdata;   // blink_on, blink_count, velocity_x,
                                                // velocity_y, area_growth, blink_rate
    logic                            m_tuser;   // growth_invalid
    logic                            cfg_wr_en;
    logic [7:0]                      cfg_wr_data;

    frame_scoreboard board;
    int              send_idle_pct = 7;
    int              recv_idle_pct = 53;
    int              hold_request  = 0;

    // random walk of the observed blob
    bit [11:0]       walk_x;
    bit [11:0]       walk_y;
    bit [23:0]       walk_area;
    bit [31:0]       clock_ms;
    bit [31:0]       time_step;

    blob_blink_motion_tracker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [bbmt_pkg::IN_DATA_W-1:0] pack_frame(frame_t f);
        logic [bbmt_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[bbmt_pkg::IN_PRESENT]           = f.present;
        d[bbmt_pkg::IN_X_LSB +: 12]       = f.pos_x;
        d[bbmt_pkg::IN_Y_LSB +: 12]       = f.pos_y;
        d[bbmt_pkg::IN_AREA_LSB +: 24]    = f.area;
        d[bbmt_pkg::IN_TIME_LSB +: 32]    = f.time_ms;
        return d;
    endfunction

    function automatic report_t unpack_report(logic [bbmt_pkg::OUT_DATA_W-1:0] d,
                                              logic flag);
        report_t r;
        r.blink_on       = d[bbmt_pkg::OUT_ON];
        r.blink_count    = d[bbmt_pkg::OUT_COUNT_LSB +: 16];
        r.vel_x          = d[bbmt_pkg::OUT_VX_LSB +: 13];
        r.vel_y          = d[bbmt_pkg::OUT_VY_LSB +: 13];
        r.growth         = d[bbmt_pkg::OUT_GROW_LSB +: 32];
        r.rate           = d[bbmt_pkg::OUT_RATE_LSB +: 26];
        r.growth_invalid = flag;
        return r;
    endfunction

    // result side: check each accepted beat, then choose the next tready
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_report(unpack_report(m_tdata, m_tuser));
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one beat, with a random gap first, and wait for it to be taken
    task automatic send_frame(frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= (f.cmd == CMD_CLEAR);
        s_tdata  <= pack_frame(f);
        do
            @(posedge clk);
        while (!s_tready);
        board.note_frame(f);
    endtask

    task automatic send_obs(bit present, bit [11:0] x, bit [11:0] y, bit [23:0] a,
                            bit [31:0] t);
        frame_t f;
        f = '{CMD_FRAME, present, x, y, a, t};
        send_frame(f);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
    endtask

    // threshold writes only with nothing in flight
    task automatic write_threshold(bit [7:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_threshold(value);
    endtask

    // next frame of the walking blob
    task automatic next_observation(bit present);
        frame_t f;
        if ($urandom_range(15) == 0)
        begin
            walk_x = 12'($urandom_range(4095));
            walk_y = 12'($urandom_range(4095));
        end
        else
        begin
            walk_x = walk_x + 12'($urandom_range(16)) - 12'd8;
            walk_y = walk_y + 12'($urandom_range(16)) - 12'd8;
        end
        case ($urandom_range(15))
            0:       walk_area = '0;
            1:       walk_area = 24'hFF_FFFF;
            2:       walk_area = 24'($urandom_range(24'hFF_FFFF));
            3:       walk_area = 24'd1;
            default: walk_area = walk_area + 24'($urandom_range(64)) - 24'd32;
        endcase
        clock_ms = clock_ms + time_step;
        f = '{CMD_FRAME, present, walk_x, walk_y, walk_area, clock_ms};
        send_frame(f);
    endtask

    // any beat at all, clears among them
    task automatic send_noise();
        frame_t f;
        f.cmd     = ($urandom_range(3) == 0) ? CMD_CLEAR : CMD_FRAME;
        f.present = 1'($urandom_range(1));
        f.pos_x   = 12'($urandom_range(4095));
        f.pos_y   = 12'($urandom_range(4095));
        f.area    = 24'($urandom_range(24'hFF_FFFF));
        f.time_ms = $urandom;
        send_frame(f);
    endtask

    // mostly debounce episodes: a present run, then an absent run
    task automatic run_phase(bit [7:0] thr, int send_pct, int recv_pct, int n_items);
        int sent;
        int run_len;
        int gap_len;
        int i;
        bit held;
        bit paused;
        write_threshold(thr);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            // long receiver hold-off while beats keep coming
            if (!held && sent >= n_items / 3)
            begin
                hold_request = 300;
                held         = 1'b1;
            end
            // sender waits for every owed result
            if (!paused && sent >= (2 * n_items) / 3)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 8)
            begin
                send_noise();
                sent++;
            end
            else
            begin
                case ($urandom_range(7))
                    0:
                    begin
                        time_step = '0;
                        clock_ms  = board.last_blink_at;
                    end
                    1:       time_step = $urandom_range(1, 3);
                    2:       time_step = $urandom;
                    default: time_step = $urandom_range(20, 50);
                endcase
                run_len = ($urandom_range(6) == 0) ? $urandom_range(1, thr + 1)
                                                   : thr + $urandom_range(6);
                gap_len = ($urandom_range(1) == 1) ? thr + $urandom_range(3)
                                                   : $urandom_range(thr);
                for (i = 0; i < run_len && sent < n_items; i++)
                begin
                    next_observation(1'b1);
                    sent++;
                end
                for (i = 0; i < gap_len && sent < n_items; i++)
                begin
                    next_observation(1'b0);
                    sent++;
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        frame_t f;
        int     i;
        int     drain_cycles;
        board = new();
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        walk_x    = 12'd2048;
        walk_y    = 12'd2048;
        walk_area = 24'd5000;
        clock_ms  = 32'd1000;
        time_step = 32'd33;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear with every field at its top, then an absent frame likewise
        f = '{CMD_CLEAR, 1'b1, 12'hFFF, 12'hFFF, 24'hFF_FFFF, 32'hFFFF_FFFF};
        send_frame(f);
        send_obs(1'b0, 12'hFFF, 12'hFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        // build up to the reset threshold; blink at the last blink time, growth saturates
        send_obs(1'b1, 12'd0,   12'd0,   24'd0,        32'd100);
        send_obs(1'b1, 12'hFFF, 12'hFFF, 24'hFF_FFFF, 32'd133);
        send_obs(1'b1, 12'd0,   12'd0,   24'd1,        32'd166);
        send_obs(1'b1, 12'd0,   12'd0,   24'd1,        32'd200);
        send_obs(1'b1, 12'hFFF, 12'd0,   24'hFF_FFFF, 32'd0);
        // extreme velocities and the most negative growth
        send_obs(1'b1, 12'd0,   12'hFFF, 24'd0,        32'd1);
        // zero previous area, then a clean doubling
        send_obs(1'b1, 12'd0,   12'hFFF, 24'd5,        32'd2);
        send_obs(1'b1, 12'd0,   12'hFFF, 24'd10,       32'd3);
        // a single dropout: velocity held, growth from the absent frame's area
        send_obs(1'b0, 12'd7,   12'd7,   24'd20,       32'd4);
        send_obs(1'b1, 12'd9,   12'd9,   24'd20,       32'd5);
        // drain to zero so blink_on clears
        for (i = 0; i < 5; i++)
            send_obs(1'b0, 12'd5, 12'd5, 24'd30, 32'd6);
        // new blink one millisecond after the last
        for (i = 0; i < 5; i++)
            send_obs(1'b1, 12'd5, 12'd6, 24'd30, 32'd1);
        // threshold dropped under the counter: next present frame clamps it
        write_threshold(8'd2);
        send_obs(1'b1, 12'd6, 12'd6, 24'd31, 32'd40);
        send_obs(1'b0, 12'd6, 12'd6, 24'd31, 32'd41);
        f = '{CMD_CLEAR, 1'b0, 12'd0, 12'd0, 24'd0, 32'd0};
        send_frame(f);
        // threshold zero: every present frame is stable
        write_threshold(8'd0);
        send_obs(1'b1, 12'd100, 12'd200, 24'd400, 32'd0);
        send_obs(1'b0, 12'd100, 12'd200, 24'd400, 32'd10);
        send_obs(1'b1, 12'd110, 12'd190, 24'd300, 32'd77);

        // random phases: sender idles little and receiver much, then the reverse, then none
        run_phase(8'd1,   7,  53, 130);
        run_phase(8'd5,   7,  53, 130);
        run_phase(8'd255, 53, 7,  280);
        run_phase(8'd2,   53, 7,  90);
        run_phase(8'd0,   0,  0,  70);
        run_phase(8'($urandom_range(3, 12)), 0, 0, 120);

        // wait for the owed results, then a quiet stretch for stray beats
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (board.pending() > 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (board.pending() > 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #60_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
